// File: rtl/core/gtw_pkg.sv
// Shared types, constants and the glyph table of the graphic LCD text writer.
package gtw_pkg;

  localparam int HalfWidth    = 64;
  localparam int GlyphColumns = 5;
  localparam int RomCols      = 5;
  localparam int QueueDepth   = 2;

  localparam logic [6:0] WrapColumn = 7'd120;
  localparam logic [7:0] FirstCode  = 8'd32;
  localparam logic [7:0] LastCode   = 8'd122;
  localparam logic [7:0] CmdPage    = 8'hB8;
  localparam logic [7:0] CmdColumn  = 8'h40;
  localparam logic [7:0] BlankByte  = 8'h00;

  localparam logic FuncCursor = 1'b0;
  localparam logic FuncChar   = 1'b1;

  typedef logic [0:RomCols-1][7:0] glyph_row_t;

  typedef struct packed {
    logic       func;
    logic [2:0] page;
    logic [6:0] column;
    logic       printable;
    glyph_row_t row;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAGE,
    ST_COL,
    ST_DATA
  } st_e;

  function automatic glyph_row_t glyph_row(input logic [6:0] idx);
    glyph_row_t row;
    unique case (idx)
      7'd0:  row = 40'h00_00_00_00_00;
      7'd1:  row = 40'h00_00_2f_00_00;
      7'd2:  row = 40'h00_07_00_07_00;
      7'd3:  row = 40'h14_7f_14_7f_14;
      7'd4:  row = 40'h24_2a_7f_2a_12;
      7'd5:  row = 40'h23_13_08_64_62;
      7'd6:  row = 40'h36_49_55_22_50;
      7'd7:  row = 40'h00_05_03_00_00;
      7'd8:  row = 40'h00_1c_22_41_00;
      7'd9:  row = 40'h00_41_22_1c_00;
      7'd10: row = 40'h14_08_3e_08_14;
      7'd11: row = 40'h08_08_3e_08_08;
      7'd12: row = 40'h00_50_30_00_00;
      7'd13: row = 40'h08_08_08_08_08;
      7'd14: row = 40'h00_60_60_00_00;
      7'd15: row = 40'h20_10_08_04_02;
      7'd16: row = 40'h3e_51_49_45_3e;
      7'd17: row = 40'h00_42_7f_40_00;
      7'd18: row = 40'h42_61_51_49_46;
      7'd19: row = 40'h21_41_45_4b_31;
      7'd20: row = 40'h18_14_12_7f_10;
      7'd21: row = 40'h27_45_45_45_39;
      7'd22: row = 40'h3c_4a_49_49_30;
      7'd23: row = 40'h01_71_09_05_03;
      7'd24: row = 40'h36_49_49_49_36;
      7'd25: row = 40'h06_49_49_29_1e;
      7'd26: row = 40'h00_36_36_00_00;
      7'd27: row = 40'h00_56_36_00_00;
      7'd28: row = 40'h08_14_22_41_00;
      7'd29: row = 40'h14_14_14_14_14;
      7'd30: row = 40'h00_41_22_14_08;
      7'd31: row = 40'h02_01_51_09_06;
      7'd32: row = 40'h32_49_79_41_3e;
      7'd33: row = 40'h7e_11_11_11_7e;
      7'd34: row = 40'h7f_49_49_49_36;
      7'd35: row = 40'h3e_41_41_41_22;
      7'd36: row = 40'h7f_41_41_22_1c;
      7'd37: row = 40'h7f_49_49_49_41;
      7'd38: row = 40'h7f_09_09_09_01;
      7'd39: row = 40'h3e_41_49_49_7a;
      7'd40: row = 40'h7f_08_08_08_7f;
      7'd41: row = 40'h00_41_7f_41_00;
      7'd42: row = 40'h20_40_41_3f_01;
      7'd43: row = 40'h7f_08_14_22_41;
      7'd44: row = 40'h7f_40_40_40_40;
      7'd45: row = 40'h7f_02_0c_02_7f;
      7'd46: row = 40'h7f_04_08_10_7f;
      7'd47: row = 40'h3e_41_41_41_3e;
      7'd48: row = 40'h7f_09_09_09_06;
      7'd49: row = 40'h3e_41_51_21_5e;
      7'd50: row = 40'h7f_09_19_29_46;
      7'd51: row = 40'h46_49_49_49_31;
      7'd52: row = 40'h01_01_7f_01_01;
      7'd53: row = 40'h3f_40_40_40_3f;
      7'd54: row = 40'h1f_20_40_20_1f;
      7'd55: row = 40'h3f_40_38_40_3f;
      7'd56: row = 40'h63_14_08_14_63;
      7'd57: row = 40'h07_08_70_08_07;
      7'd58: row = 40'h61_51_49_45_43;
      7'd59: row = 40'h00_7f_41_41_00;
      7'd60: row = 40'h02_04_08_10_20;
      7'd61: row = 40'h00_41_41_7f_00;
      7'd62: row = 40'h04_02_01_02_04;
      7'd63: row = 40'h40_40_40_40_40;
      7'd64: row = 40'h00_01_02_04_00;
      7'd65: row = 40'h20_54_54_54_78;
      7'd66: row = 40'h7f_48_44_44_38;
      7'd67: row = 40'h38_44_44_44_20;
      7'd68: row = 40'h38_44_44_48_7f;
      7'd69: row = 40'h38_54_54_54_18;
      7'd70: row = 40'h08_7e_09_01_02;
      7'd71: row = 40'h0c_52_52_52_3e;
      7'd72: row = 40'h7f_08_04_04_78;
      7'd73: row = 40'h00_44_7d_40_00;
      7'd74: row = 40'h20_40_44_3d_00;
      7'd75: row = 40'h7f_10_28_44_00;
      7'd76: row = 40'h00_41_7f_40_00;
      7'd77: row = 40'h7c_04_18_04_78;
      7'd78: row = 40'h7c_08_04_04_78;
      7'd79: row = 40'h38_44_44_44_38;
      7'd80: row = 40'h7c_14_14_14_08;
      7'd81: row = 40'h08_14_14_18_7c;
      7'd82: row = 40'h7c_08_04_04_08;
      7'd83: row = 40'h48_54_54_54_20;
      7'd84: row = 40'h04_3f_44_40_20;
      7'd85: row = 40'h3c_40_40_20_7c;
      7'd86: row = 40'h1c_20_40_20_1c;
      7'd87: row = 40'h3c_40_30_40_3c;
      7'd88: row = 40'h44_28_10_28_44;
      7'd89: row = 40'h0c_50_50_50_3c;
      7'd90: row = 40'h44_64_54_4c_44;
      default: row = '0;
    endcase
    return row;
  endfunction

endpackage

// File: rtl/core/glcd_text_writer.sv
// Top level of the graphic LCD text writer.
//
// Input words (func, page, column, char_code) are offered with push and taken at an
// edge where push is high and full is low. A set-cursor word yields two command
// writes; a character yields up to eight writes (two wrap commands or two
// right-half cursor commands, the glyph columns and one blank column); an
// unprintable character without a wrap yields none. Each write appears on the
// result ports while empty is low and is taken with pop; last marks the final
// write of a word.
// An accepted word is written into the queue, loaded into the sequencer state of the
// back end once that is free, and each of its writes is then registered in the result
// register. The back end issues one write per cycle while the result register is free
// (empty or popped), and it loads the next word as it issues the last write of a word.
// A two-word queue lets the front end keep accepting while the back end works.
// If pop stays low the result is held and the sequencer waits, the queue fills
// and full rises. Reset clears the cursor to page 0, column 0 and empties the
// queue and the result register.
module glcd_text_writer #(
  parameter int GLYPH_COLUMNS = gtw_pkg::GlyphColumns
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic       func_i,
  input  logic [2:0] page_i,
  input  logic [6:0] column_i,
  input  logic [7:0] char_code_i,
  output logic       empty,
  input  logic       pop,
  output logic       right_half_o,
  output logic       is_data_o,
  output logic [7:0] bus_byte_o,
  output logic       last_o
);
  import gtw_pkg::*;

  cmd_t q_entry, q_head;
  logic q_push, q_full, q_valid, q_pop;

  gtw_front u_front (
    .push        (push),
    .full        (full),
    .func_i      (func_i),
    .page_i      (page_i),
    .column_i    (column_i),
    .char_code_i (char_code_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_entry_o   (q_entry)
  );

  gtw_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .head_o  (q_head)
  );

  gtw_back #(
    .GLYPH_COLUMNS (GLYPH_COLUMNS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_head_i     (q_head),
    .q_pop_o      (q_pop),
    .empty        (empty),
    .pop          (pop),
    .right_half_o (right_half_o),
    .is_data_o    (is_data_o),
    .bus_byte_o   (bus_byte_o),
    .last_o       (last_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> q_valid)
    else $error("Back end took a word from an empty queue.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !is_data_o) |-> (bus_byte_o[7:3] == 5'b10111 || bus_byte_o[7:6] == 2'b01))
    else $error("Command write carries neither a page nor a column command.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && is_data_o && last_o) |-> (bus_byte_o == BlankByte))
    else $error("Final data write of a character is not the blank column.");

endmodule

// File: rtl/core/gtw_front.sv
// Front end: accepts input words, classifies them and looks up the glyph row.
module gtw_front (
  input  logic          push,
  output logic          full,
  input  logic          func_i,
  input  logic [2:0]    page_i,
  input  logic [6:0]    column_i,
  input  logic [7:0]    char_code_i,
  input  logic          q_full_i,
  output logic          q_push_o,
  output gtw_pkg::cmd_t q_entry_o
);
  import gtw_pkg::*;

  logic       printable;
  logic [6:0] glyph_idx;

  assign printable = (char_code_i >= FirstCode) && (char_code_i <= LastCode);
  assign glyph_idx = printable ? 7'(char_code_i - FirstCode) : 7'd0;

  assign full     = q_full_i;
  assign q_push_o = push && !q_full_i;

  always_comb begin
    q_entry_o.func      = func_i;
    q_entry_o.page      = page_i;
    q_entry_o.column    = column_i;
    q_entry_o.printable = (func_i == FuncChar) && printable;
    q_entry_o.row       = glyph_row(glyph_idx);
  end

endmodule

// File: rtl/core/gtw_queue.sv
// Short queue of classified words between the front end and the back end.
module gtw_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  gtw_pkg::cmd_t entry_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output gtw_pkg::cmd_t head_o
);
  import gtw_pkg::*;

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  cmd_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push_ok, pop_ok;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop_i && valid_o;
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_ok) begin
      wr_d = (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_ok) begin
      rd_d = (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    case ({push_ok, pop_ok})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

// File: rtl/core/gtw_back.sv
// Back end: cursor state, write sequencer and the output register.
module gtw_back #(
  parameter int GLYPH_COLUMNS = gtw_pkg::GlyphColumns
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  gtw_pkg::cmd_t q_head_i,
  output logic          q_pop_o,
  output logic          empty,
  input  logic          pop,
  output logic          right_half_o,
  output logic          is_data_o,
  output logic [7:0]    bus_byte_o,
  output logic          last_o
);
  import gtw_pkg::*;

  localparam int IdxW = $clog2(GLYPH_COLUMNS + 1);

  st_e             state_q, state_d;
  logic [6:0]      col_q, col_d, col_a;
  logic [2:0]      page_q, page_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            draw_q, draw_d;
  glyph_row_t      row_q, row_d;

  logic            out_valid_q, out_valid_d;
  logic            out_half_q, out_data_q, out_last_q;
  logic [7:0]      out_byte_q;

  logic            free, emit, load;
  logic            w_half, w_data, w_last;
  logic [7:0]      w_byte;
  logic [6:0]      half_col, col_inc;
  logic [2:0]      rom_sel;
  st_e             nxt;

  assign free     = !out_valid_q || pop;
  assign emit     = (state_q != ST_IDLE) && free;
  assign w_half   = (col_q >= HalfWidth);
  assign half_col = w_half ? 7'(col_q - 7'(HalfWidth)) : col_q;
  assign col_inc  = col_q + 7'd1;
  assign rom_sel  = 3'(idx_q);

  always_comb begin
    w_data = 1'b0;
    w_last = 1'b0;
    w_byte = BlankByte;
    nxt    = ST_IDLE;
    unique case (state_q)
      ST_IDLE: begin
        nxt = ST_IDLE;
      end
      ST_PAGE: begin
        w_byte = CmdPage | {5'd0, page_q};
        nxt    = ST_COL;
      end
      ST_COL: begin
        w_byte = CmdColumn | {2'd0, half_col[5:0]};
        w_last = !draw_q;
        nxt    = draw_q ? ST_DATA : ST_IDLE;
      end
      ST_DATA: begin
        w_data = 1'b1;
        w_byte = (idx_q < IdxW'(GLYPH_COLUMNS) && idx_q < RomCols) ? row_q[rom_sel]
                                                                     : BlankByte;
        w_last = (idx_q == IdxW'(GLYPH_COLUMNS));
        if (w_last) begin
          nxt = ST_IDLE;
        end else if (col_inc == HalfWidth) begin
          nxt = ST_PAGE;
        end else begin
          nxt = ST_DATA;
        end
      end
      default: begin
        nxt = ST_IDLE;
      end
    endcase
  end

  assign load    = (state_q == ST_IDLE) || (emit && w_last);
  assign q_pop_o = load && q_valid_i;
  assign col_a   = (emit && state_q == ST_DATA) ? col_inc : col_q;

  always_comb begin
    state_d = emit ? nxt : state_q;
    col_d   = col_a;
    page_d  = page_q;
    idx_d   = (emit && state_q == ST_DATA) ? idx_q + 1'b1 : idx_q;
    draw_d  = draw_q;
    row_d   = row_q;
    if (q_pop_o) begin
      idx_d  = '0;
      row_d  = q_head_i.row;
      draw_d = q_head_i.printable;
      if (q_head_i.func == FuncCursor) begin
        page_d  = q_head_i.page;
        col_d   = q_head_i.column;
        draw_d  = 1'b0;
        state_d = ST_PAGE;
      end else if (col_a >= WrapColumn) begin
        page_d  = page_q + 3'd1;
        col_d   = '0;
        state_d = ST_PAGE;
      end else if (q_head_i.printable) begin
        state_d = (col_a == HalfWidth) ? ST_PAGE : ST_DATA;
      end else begin
        state_d = ST_IDLE;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      col_q       <= '0;
      page_q      <= '0;
      idx_q       <= '0;
      draw_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      page_q      <= page_d;
      idx_q       <= idx_d;
      draw_q      <= draw_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q <= row_d;
    if (emit) begin
      out_half_q <= w_half;
      out_data_q <= w_data;
      out_byte_q <= w_byte;
      out_last_q <= w_last;
    end
  end

  assign empty        = !out_valid_q;
  assign right_half_o = out_half_q;
  assign is_data_o    = out_data_q;
  assign bus_byte_o   = out_byte_q;
  assign last_o       = out_last_q;

endmodule
